// ===== rtl/core/mfs_pkg.sv =====
// Shared types and constants of the management frame serializer.
// Used by the front end, the job queue, the back end and the top level.
// No dependencies.
package mfs_pkg;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned MAX_SSID   = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);

  // Index of the final byte of the non-trailer part of each frame shape, and of the trailer.
  localparam logic [5:0] LAST_SHORT = 6'd25;  // deauth, disassoc, probe request
  localparam logic [5:0] LAST_AUTH  = 6'd29;
  localparam logic [5:0] LAST_LONG  = 6'd37;  // beacon, probe response
  localparam logic [5:0] TRL_LAST   = 6'd12;

  localparam logic [3:0] SUB_DEAUTH   = 4'hC;
  localparam logic [3:0] SUB_DISASSOC = 4'hA;
  localparam logic [3:0] SUB_AUTH     = 4'hB;
  localparam logic [3:0] SUB_BEACON   = 4'h8;
  localparam logic [3:0] SUB_PREQ     = 4'h4;
  localparam logic [3:0] SUB_PRESP    = 4'h5;

  localparam logic [7:0] BEACON_INTERVAL = 8'h64;
  localparam logic [7:0] CAP_PRIVACY     = 8'h11;
  localparam logic [7:0] CAP_PLAIN       = 8'h01;
  localparam logic [7:0] EID_RATES       = 8'h01;
  localparam logic [7:0] RATES_LEN       = 8'h08;
  localparam logic [7:0] EID_DS          = 8'h03;
  localparam logic [7:0] DS_LEN          = 8'h01;

  localparam logic [7:0] RATE_TABLE [8] = '{
    8'h82, 8'h84, 8'h8B, 8'h96, 8'h0C, 8'h12, 8'h18, 8'h24
  };

  typedef enum logic [2:0] {
    CMD_DEAUTH   = 3'd0,
    CMD_DISASSOC = 3'd1,
    CMD_AUTH     = 3'd2,
    CMD_BEACON   = 3'd3,
    CMD_PREQ     = 3'd4,
    CMD_PRESP    = 3'd5,
    CMD_SSID     = 3'd6,
    CMD_NONE     = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_SSID_LEN = 2'd1,
    ERR_BAD_DEST = 2'd2,
    ERR_STRAY    = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    OP_ERR   = 2'd0,
    OP_SSID  = 2'd1,
    OP_FRAME = 2'd2
  } op_e;

  typedef enum logic {
    PH_MAIN  = 1'b0,
    PH_TRAIL = 1'b1
  } phase_e;

  // One unit of work for the back end: an error byte, or one SSID byte or a
  // frame header with its fixed body, either optionally followed by the trailer.
  typedef struct packed {
    op_e               op;
    err_e              err;
    cmd_e              kind;
    logic [3:0]        subtype;
    logic [ADDR_W-1:0] a1;
    logic [ADDR_W-1:0] a2;
    logic [ADDR_W-1:0] a3;
    logic [11:0]       seq;
    logic [15:0]       reason;
    logic [7:0]        cap;
    logic [7:0]        slen;
    logic [7:0]        data;
    logic [5:0]        main_last;
    logic              close;
    logic              trailer;
    logic [7:0]        channel;
  } job_t;

endpackage

// ===== rtl/core/mfs_front.sv =====
// Front end: accepts input items, checks them against the frame state and
// turns each item other than CMD_NONE into a job for the back end. Depends on mfs_pkg.
module mfs_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                cmd_i,
  input  logic [mfs_pkg::ADDR_W-1:0] dest_addr_i,
  input  logic [mfs_pkg::ADDR_W-1:0] source_addr_i,
  input  logic [mfs_pkg::ADDR_W-1:0] bss_addr_i,
  input  logic [15:0]               reason_code_i,
  input  logic [11:0]               seq_number_i,
  input  logic [7:0]                channel_i,
  input  logic                      privacy_i,
  input  logic [7:0]                ssid_length_i,
  input  logic [7:0]                ssid_byte_i,
  input  logic                      full_i,
  output logic                      push_o,
  output mfs_pkg::job_t             job_o
);
  import mfs_pkg::*;

  localparam logic [ADDR_W-1:0] BCAST = '1;

  cmd_e       cmd;
  logic       accept;
  logic       make_job;
  logic       in_frame_q, in_frame_d;
  logic [5:0] remain_q, remain_d;
  logic [7:0] chan_q, chan_d;
  logic [5:0] remain_dec;
  job_t       job;

  assign cmd        = cmd_e'(cmd_i);
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign remain_dec = remain_q - 6'd1;

  always_comb begin
    job            = '0;
    job.op         = OP_FRAME;
    job.err        = ERR_NONE;
    job.kind       = cmd;
    job.a1         = dest_addr_i;
    job.a2         = source_addr_i;
    job.a3         = bss_addr_i;
    job.seq        = seq_number_i;
    job.reason     = reason_code_i;
    job.cap        = CAP_PLAIN;
    job.slen       = ssid_length_i;
    job.data       = ssid_byte_i;
    job.channel    = chan_q;
    make_job       = 1'b1;
    in_frame_d     = in_frame_q;
    remain_d       = remain_q;
    chan_d         = chan_q;

    unique case (cmd)
      CMD_NONE: begin
        make_job = 1'b0;
      end
      CMD_SSID: begin
        if (!in_frame_q || remain_q == '0) begin
          job.op    = OP_ERR;
          job.err   = ERR_STRAY;
          job.close = 1'b1;
        end else begin
          job.op   = OP_SSID;
          remain_d = remain_dec;
          if (remain_dec == '0) begin
            job.trailer = 1'b1;
            in_frame_d  = 1'b0;
          end
        end
      end
      CMD_DEAUTH, CMD_DISASSOC: begin
        in_frame_d    = 1'b0;
        remain_d      = '0;
        job.subtype   = (cmd == CMD_DEAUTH) ? SUB_DEAUTH : SUB_DISASSOC;
        job.main_last = LAST_SHORT;
        job.close     = 1'b1;
      end
      CMD_AUTH: begin
        in_frame_d    = 1'b0;
        remain_d      = '0;
        job.subtype   = SUB_AUTH;
        job.a1        = bss_addr_i;
        job.main_last = LAST_AUTH;
        job.close     = 1'b1;
      end
      CMD_BEACON, CMD_PREQ, CMD_PRESP: begin
        in_frame_d = 1'b0;
        remain_d   = '0;
        if (cmd == CMD_PRESP && (dest_addr_i == BCAST || dest_addr_i == '0)) begin
          job.op    = OP_ERR;
          job.err   = ERR_BAD_DEST;
          job.close = 1'b1;
        end else if (ssid_length_i > 8'(MAX_SSID) ||
                     (ssid_length_i == '0 && cmd != CMD_PREQ)) begin
          job.op    = OP_ERR;
          job.err   = ERR_SSID_LEN;
          job.close = 1'b1;
        end else begin
          chan_d      = channel_i;
          job.channel = channel_i;
          if (cmd == CMD_BEACON) begin
            job.subtype   = SUB_BEACON;
            job.a1        = BCAST;
            job.a2        = bss_addr_i;
            job.cap       = privacy_i ? CAP_PRIVACY : CAP_PLAIN;
            job.main_last = LAST_LONG;
          end else if (cmd == CMD_PREQ) begin
            job.subtype   = SUB_PREQ;
            job.a1        = BCAST;
            job.a3        = BCAST;
            job.main_last = LAST_SHORT;
          end else begin
            job.subtype   = SUB_PRESP;
            job.a2        = bss_addr_i;
            job.main_last = LAST_LONG;
          end
          if (ssid_length_i == '0) begin
            job.trailer = 1'b1;
          end else begin
            remain_d   = ssid_length_i[5:0];
            in_frame_d = 1'b1;
          end
        end
      end
      default: begin
        make_job = 1'b0;
      end
    endcase
  end

  assign push_o = accept && make_job;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      remain_q   <= '0;
      chan_q     <= '0;
    end else if (accept) begin
      in_frame_q <= in_frame_d;
      remain_q   <= remain_d;
      chan_q     <= chan_d;
    end
  end

endmodule

// ===== rtl/core/mfs_queue.sv =====
// Short job queue between the front end and the back end.
// Register based, one write and one read port. Depends on mfs_pkg.
module mfs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfs_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output mfs_pkg::job_t head_o
);
  import mfs_pkg::*;

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/mfs_back.sv =====
// Back end: walks the head job byte by byte, appends the rates and DS
// elements when asked, and drives the output register. Depends on mfs_pkg.
module mfs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  mfs_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          last_o,
  output logic [1:0]    error_o
);
  import mfs_pkg::*;

  localparam logic [5:0] IDX_A1   = 6'd4;
  localparam logic [5:0] IDX_A2   = 6'd10;
  localparam logic [5:0] IDX_A3   = 6'd16;
  localparam logic [5:0] IDX_SEQL = 6'd22;
  localparam logic [5:0] IDX_SEQH = 6'd23;
  localparam logic [5:0] IDX_BODY = 6'd24;
  localparam logic [5:0] TRL_RATE0 = 6'd2;
  localparam logic [5:0] TRL_RATE7 = 6'd9;

  phase_e     phase_q, phase_d;
  logic [5:0] idx_q, idx_d;
  logic       fire, at_end;
  logic [7:0] frame_byte, main_byte, trail_byte, byte_d;
  logic       last_d;
  err_e       err_d;
  logic [5:0] body_k;
  logic [2:0] rate_sel;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  err_e       err_q;

  function automatic logic [7:0] addr_octet(logic [ADDR_W-1:0] a, logic [5:0] off);
    logic [7:0] r;
    unique case (off)
      6'd0:    r = a[47:40];
      6'd1:    r = a[39:32];
      6'd2:    r = a[31:24];
      6'd3:    r = a[23:16];
      6'd4:    r = a[15:8];
      6'd5:    r = a[7:0];
      default: r = '0;
    endcase
    return r;
  endfunction

  assign fire     = job_valid_i && (!valid_q || out_ready_i);
  assign body_k   = idx_q - IDX_BODY;
  assign rate_sel = 3'(idx_q - TRL_RATE0);

  // Header and fixed body of a frame job.
  always_comb begin
    frame_byte = '0;
    if (idx_q == '0) begin
      frame_byte = {job_i.subtype, 4'h0};
    end else if (idx_q < IDX_A1) begin
      frame_byte = '0;
    end else if (idx_q < IDX_A2) begin
      frame_byte = addr_octet(job_i.a1, idx_q - IDX_A1);
    end else if (idx_q < IDX_A3) begin
      frame_byte = addr_octet(job_i.a2, idx_q - IDX_A2);
    end else if (idx_q < IDX_SEQL) begin
      frame_byte = addr_octet(job_i.a3, idx_q - IDX_A3);
    end else if (idx_q == IDX_SEQL) begin
      frame_byte = {job_i.seq[3:0], 4'h0};
    end else if (idx_q == IDX_SEQH) begin
      frame_byte = job_i.seq[11:4];
    end else begin
      unique case (job_i.kind)
        CMD_DEAUTH, CMD_DISASSOC: begin
          frame_byte = (body_k == 6'd0) ? job_i.reason[7:0] : job_i.reason[15:8];
        end
        CMD_AUTH: begin
          frame_byte = (body_k == 6'd2) ? 8'h01 : 8'h00;
        end
        CMD_BEACON, CMD_PRESP: begin
          if (body_k == 6'd8) begin
            frame_byte = BEACON_INTERVAL;
          end else if (body_k == 6'd10) begin
            frame_byte = job_i.cap;
          end else if (body_k == 6'd13) begin
            frame_byte = job_i.slen;
          end else begin
            frame_byte = '0;
          end
        end
        CMD_PREQ: begin
          frame_byte = (body_k == 6'd1) ? job_i.slen : 8'h00;
        end
        default: begin
          frame_byte = '0;
        end
      endcase
    end
  end

  always_comb begin
    unique case (job_i.op)
      OP_SSID:  main_byte = job_i.data;
      OP_FRAME: main_byte = frame_byte;
      default:  main_byte = '0;
    endcase
  end

  // Supported rates element followed by the DS parameter set element.
  always_comb begin
    if (idx_q == 6'd0) begin
      trail_byte = EID_RATES;
    end else if (idx_q == 6'd1) begin
      trail_byte = RATES_LEN;
    end else if (idx_q <= TRL_RATE7) begin
      trail_byte = RATE_TABLE[rate_sel];
    end else if (idx_q == TRL_RATE7 + 6'd1) begin
      trail_byte = EID_DS;
    end else if (idx_q == TRL_RATE7 + 6'd2) begin
      trail_byte = DS_LEN;
    end else begin
      trail_byte = job_i.channel;
    end
  end

  // Next-state logic of the byte sequencer.
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    if (fire) begin
      unique case (phase_q)
        PH_MAIN: begin
          if (idx_q == job_i.main_last) begin
            phase_d = job_i.trailer ? PH_TRAIL : PH_MAIN;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
        PH_TRAIL: begin
          if (idx_q == TRL_LAST) begin
            phase_d = PH_MAIN;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
        default: begin
          phase_d = PH_MAIN;
          idx_d   = '0;
        end
      endcase
    end
  end

  // Output logic of the byte sequencer.
  always_comb begin
    unique case (phase_q)
      PH_MAIN: begin
        at_end = (idx_q == job_i.main_last);
        byte_d = main_byte;
        last_d = at_end && job_i.close;
        err_d  = (job_i.op == OP_ERR) ? job_i.err : ERR_NONE;
        pop_o  = fire && at_end && !job_i.trailer;
      end
      PH_TRAIL: begin
        at_end = (idx_q == TRL_LAST);
        byte_d = trail_byte;
        last_d = at_end;
        err_d  = ERR_NONE;
        pop_o  = fire && at_end;
      end
      default: begin
        at_end = 1'b0;
        byte_d = '0;
        last_d = 1'b0;
        err_d  = ERR_NONE;
        pop_o  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAIN;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      if (fire) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;
  assign error_o     = err_q;

endmodule

// ===== rtl/core/mgmt_frame_serializer.sv =====
// Management frame serializer: each item's job is written to the job queue,
// and the back end loads each result byte from its head into the output register.
// SSID items are taken one per cycle while the queue is not full; results leave
// one byte per cycle while the output is ready, so a start item's job is 26, 30 or 38 bytes plus 13 for the trailer,
// and the four-entry job queue lets the front keep taking items while the back end walks it.
// Reset clears the frame state, queue pointers and the output valid at once.
module mgmt_frame_serializer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                cmd_i,
  input  logic [mfs_pkg::ADDR_W-1:0] dest_addr_i,
  input  logic [mfs_pkg::ADDR_W-1:0] source_addr_i,
  input  logic [mfs_pkg::ADDR_W-1:0] bss_addr_i,
  input  logic [15:0]               reason_code_i,
  input  logic [11:0]               seq_number_i,
  input  logic [7:0]                channel_i,
  input  logic                      privacy_i,
  input  logic [7:0]                ssid_length_i,
  input  logic [7:0]                ssid_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      last_o,
  output logic [1:0]                error_o
);
  import mfs_pkg::*;

  logic push, full, head_valid, pop;
  job_t job_in, job_head;

  mfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .dest_addr_i   (dest_addr_i),
    .source_addr_i (source_addr_i),
    .bss_addr_i    (bss_addr_i),
    .reason_code_i (reason_code_i),
    .seq_number_i  (seq_number_i),
    .channel_i     (channel_i),
    .privacy_i     (privacy_i),
    .ssid_length_i (ssid_length_i),
    .ssid_byte_i   (ssid_byte_i),
    .full_i        (full),
    .push_o        (push),
    .job_o         (job_in)
  );

  mfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (job_head)
  );

  mfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (job_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

endmodule

// ===== rtl/core/mfs_checker.sv =====
// Port-level checks for the management frame serializer, bound to the top.
// Depends on mfs_pkg and on the mgmt_frame_serializer port list.
module mfs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_o,
  input logic [1:0] error_o
);
  import mfs_pkg::*;

  // An error result is a single zero byte that closes its frame.
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o != ERR_NONE |-> last_o && out_byte_o == '0)
    else $error("error result without last or with nonzero byte");

  // A stalled result stays put until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
                                    $stable(last_o) && $stable(error_o))
    else $error("output changed while stalled");

  // Input backpressure only comes from a full queue, which means a pending result.
  a_ready_low_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // Nothing leaves the block in the cycle after reset is released.
  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result presented straight out of reset");

endmodule

bind mgmt_frame_serializer mfs_checker u_mfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .last_o      (last_o),
  .error_o     (error_o)
);
